[hdl/dstq_pkg.sv]
`default_nettype none
package dstq_pkg;

  localparam int TIME_W    = 48;
  localparam int DELAY_W   = 32;
  localparam int TAG_W     = 16;
  localparam int KIND_W    = 2;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int REL_CNT_W       = $clog2(MAX_RESULTS);

  // input action codes
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // result kind codes
  localparam logic [KIND_W-1:0] KIND_ADDED     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELIVERED = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_add;   // latch due time and tag of an add beat
    logic load_tick;  // advance the time base
    logic insert;     // sorted insert of the latched event
    logic pop;        // drop the head event
    logic emit_add;   // load add status into the result register
    logic emit_head;  // load head event into the result register
    logic last;       // last flag for a head result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic head_due;
    logic next_due;
    logic out_free;
  } status_t;

  // a strictly earlier than b, wrap-safe
  function automatic logic earlier(input logic [TIME_W-1:0] a,
                                   input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d[TIME_W-1];
  endfunction

  // due time reached at time now, wrap-safe
  function automatic logic reached(input logic [TIME_W-1:0] due,
                                   input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] d;
    d = due - now;
    return (d == '0) || d[TIME_W-1];
  endfunction

endpackage
`default_nettype wire

[hdl/dstq_datapath.sv]
`default_nettype none
module dstq_datapath
  import dstq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [DELAY_W-1:0] delay,
  input  wire logic [TAG_W-1:0]   tag,
  input  wire cmd_t               cmd,
  output status_t                 sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [KIND_W-1:0]       kind,
  output logic [TAG_W-1:0]        event_tag,
  output logic [TIME_W-1:0]       due_time,
  output logic                    last
);

  logic [TIME_W-1:0] clock_now;
  logic [TIME_W-1:0] new_due;
  logic [TAG_W-1:0]  new_tag;

  logic [TIME_W-1:0] cell_due [QUEUE_DEPTH];
  logic [TAG_W-1:0]  cell_tag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;

  logic [TIME_W-1:0] cell_due_next [QUEUE_DEPTH];
  logic [TAG_W-1:0]  cell_tag_next [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid_next;
  logic [QUEUE_DEPTH-1:0] stay;

  // status toward the controller
  assign sts.full     = cell_valid[QUEUE_DEPTH-1];
  assign sts.head_due = cell_valid[0] && reached(cell_due[0], clock_now);
  assign sts.next_due = cell_valid[1] && reached(cell_due[1], clock_now);
  assign sts.out_free = !out_valid || out_ready;

  // time base and latched add beat
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_now <= '0;
    end else if (cmd.load_tick) begin
      clock_now <= clock_now + TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_add) begin
      new_due <= clock_now + TIME_W'(delay);
      new_tag <= tag;
    end
  end

  // per-cell next value: keep, take new event, shift up or shift down
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic prev_stay;
    logic prev_valid;
    logic [TIME_W-1:0] up_due;
    logic [TAG_W-1:0]  up_tag;
    logic [TIME_W-1:0] dn_due;
    logic [TAG_W-1:0]  dn_tag;
    logic dn_valid;

    assign stay[g] = cell_valid[g] && !earlier(new_due, cell_due[g]);

    if (g == 0) begin : g_first
      assign prev_stay  = 1'b1;
      assign prev_valid = 1'b1;
      assign up_due     = new_due;
      assign up_tag     = new_tag;
    end else begin : g_rest
      assign prev_stay  = stay[g-1];
      assign prev_valid = cell_valid[g-1];
      assign up_due     = cell_due[g-1];
      assign up_tag     = cell_tag[g-1];
    end

    if (g == QUEUE_DEPTH-1) begin : g_top
      assign dn_due   = cell_due[g];
      assign dn_tag   = cell_tag[g];
      assign dn_valid = 1'b0;
    end else begin : g_below
      assign dn_due   = cell_due[g+1];
      assign dn_tag   = cell_tag[g+1];
      assign dn_valid = cell_valid[g+1];
    end

    always_comb begin
      cell_due_next[g]   = cell_due[g];
      cell_tag_next[g]   = cell_tag[g];
      cell_valid_next[g] = cell_valid[g];
      if (cmd.insert) begin
        cell_valid_next[g] = cell_valid[g] || prev_valid;
        if (!stay[g]) begin
          if (prev_stay) begin
            cell_due_next[g] = new_due;
            cell_tag_next[g] = new_tag;
          end else begin
            cell_due_next[g] = up_due;
            cell_tag_next[g] = up_tag;
          end
        end
      end else if (cmd.pop) begin
        cell_due_next[g]   = dn_due;
        cell_tag_next[g]   = dn_tag;
        cell_valid_next[g] = dn_valid;
      end
    end

    always_ff @(posedge clk) begin
      cell_due[g] <= cell_due_next[g];
      cell_tag[g] <= cell_tag_next[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= '0;
    end else begin
      cell_valid <= cell_valid_next;
    end
  end

  // result register: load a beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_add || cmd.emit_head) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_add) begin
      kind      <= sts.full ? KIND_FULL : KIND_ADDED;
      event_tag <= new_tag;
      due_time  <= new_due;
      last      <= 1'b1;
    end else if (cmd.emit_head) begin
      kind      <= KIND_DELIVERED;
      event_tag <= cell_tag[0];
      due_time  <= cell_due[0];
      last      <= cmd.last;
    end
  end

endmodule
`default_nettype wire

[hdl/dstq_ctrl.sv]
`default_nettype none
module dstq_ctrl
  import dstq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic    action,
  input  wire status_t sts,
  output cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_RELEASE
  } state_t;

  state_t state;
  state_t state_next;
  logic [REL_CNT_W-1:0] rel_count;
  logic [REL_CNT_W-1:0] rel_count_next;
  logic accept;
  logic final_rel;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign final_rel = !sts.next_due || (rel_count == REL_CNT_W'(MAX_RESULTS - 1));

  // decode commands and next state
  always_comb begin
    cmd            = '0;
    state_next     = state;
    rel_count_next = rel_count;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          rel_count_next = '0;
          if (action == ACT_ADD) begin
            cmd.load_add = 1'b1;
            state_next   = ST_ADD;
          end else begin
            cmd.load_tick = 1'b1;
            state_next    = ST_RELEASE;
          end
        end
      end
      ST_ADD: begin
        if (sts.out_free) begin
          cmd.emit_add = 1'b1;
          cmd.insert   = !sts.full;
          state_next   = ST_IDLE;
        end
      end
      ST_RELEASE: begin
        if (!sts.head_due) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_head  = 1'b1;
          cmd.pop        = 1'b1;
          cmd.last       = final_rel;
          rel_count_next = rel_count + REL_CNT_W'(1);
          if (final_rel) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // hold state and release count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rel_count <= '0;
    end else begin
      state     <= state_next;
      rel_count <= rel_count_next;
    end
  end

endmodule
`default_nettype wire

[hdl/deadline_sorted_timer_queue_core.sv]
// Sorted timer event queue with a microsecond time base.
// Input channel (in_valid/in_ready): action, delay, tag. An add beat places
// an event due at now + delay behind every event due at or before that time;
// a tick beat advances the time base by one and releases the due events.
// Output channel (out_valid/out_ready): kind, event_tag, due_time, last.
// An add gives one beat (accepted, or refused when the queue is full).
// A tick gives zero to 16 delivered beats; last marks the final one.
// Sequence: an add latches its due time and tag, then in ST_ADD loads its
// result into the output register once that register is free. A tick
// advances the time base, then in ST_RELEASE the controller pops one due head
// event per cycle from the sorted register file while the output register is free.
// One item is worked on at a time. The block takes the next input beat while
// a finished result waits in the output register; when the receiver stalls,
// the result holds and the block waits before writing another.
// Reset (synchronous): queue empty, time base zero, output register empty.
`default_nettype none
module deadline_sorted_timer_queue_core
  import dstq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               action,
  input  wire logic [DELAY_W-1:0] delay,
  input  wire logic [TAG_W-1:0]   tag,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [KIND_W-1:0]       kind,
  output logic [TAG_W-1:0]        event_tag,
  output logic [TIME_W-1:0]       due_time,
  output logic                    last
);

  cmd_t    cmd;
  status_t sts;

  dstq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd)
  );

  dstq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .delay     (delay),
    .tag       (tag),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .event_tag (event_tag),
    .due_time  (due_time),
    .last      (last)
  );

  // never insert into a full queue
  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !sts.full)
    else $error("insert while queue full");

  // only pop an event that is due
  a_pop_due: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> sts.head_due)
    else $error("pop of an event not yet due");

  // never overwrite a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_add || cmd.emit_head) |-> sts.out_free)
    else $error("result register overwritten");

  // one item at a time: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened right after a beat");

endmodule
`default_nettype wire
